### sv/chip8_instruction_executor_macros.svh
// Assertion macros shared by the executor RTL
`ifndef CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`ifndef SYNTHESIS
`define C8X_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define C8X_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);
`else
`define C8X_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define C8X_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

### sv/c8x_pkg.sv
// Types, opcodes and the hex font for the CHIP-8 executor
`timescale 1ns / 1ps
package c8x_pkg;

    localparam int MEM_BYTES  = 4096;
    localparam int MEM_AW     = 12;
    localparam int FONT_BYTES = 80;
    localparam int FONT_AW    = 7;
    localparam int FRAME_ROWS = 32;
    localparam int ROW_AW     = 5;
    localparam int ROW_BITS   = 64;
    localparam logic [MEM_AW-1:0] PC_RESET = 12'h200;

    typedef enum logic [1:0] {
        FN_MEM_WR = 2'd0,
        FN_EXEC   = 2'd1,
        FN_ROW_RD = 2'd2,
        FN_REG_RD = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FETCH0, S_FETCH1, S_FETCH2, S_RDX, S_RDY, S_EXEC,
        S_DRAW_M, S_DRAW_A, S_DRAW_AW, S_DRAW_B, S_DRAW_BW,
        S_LOAD_M, S_LOAD_W, S_DONE, S_ROW, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_XOR, ALU_SHR, ALU_PASS
    } t_alu_op;

    // Opcode groups (top nibble)
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_DRW  = 4'hD;
    localparam logic [3:0] OP_KEY  = 4'hE;
    localparam logic [3:0] OP_MISC = 4'hF;

    // Sub-codes (low nibble)
    localparam logic [3:0] SYS_CLS  = 4'h0;
    localparam logic [3:0] SYS_RET  = 4'hE;
    localparam logic [3:0] SUB_MOV  = 4'h0;
    localparam logic [3:0] SUB_AND  = 4'h2;
    localparam logic [3:0] SUB_XOR  = 4'h3;
    localparam logic [3:0] SUB_ADC  = 4'h4;
    localparam logic [3:0] SUB_SBC  = 4'h5;
    localparam logic [3:0] SUB_SHR  = 4'h6;
    localparam logic [3:0] KEY_SKNP = 4'h1;
    localparam logic [3:0] KEY_SKP  = 4'hE;

    // Sub-codes (low byte) of the misc group
    localparam logic [7:0] MISC_GETDT = 8'h07;
    localparam logic [7:0] MISC_SETDT = 8'h15;
    localparam logic [7:0] MISC_SETST = 8'h18;
    localparam logic [7:0] MISC_ADDI  = 8'h1E;
    localparam logic [7:0] MISC_FILL  = 8'h65;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_ctl;

    typedef struct packed {
        logic                clear;
        logic                rd;
        logic [ROW_AW-1:0]   raddr;
        logic                we;
        logic [ROW_AW-1:0]   waddr;
        logic [ROW_BITS-1:0] wdata;
    } t_frame_ctl;

endpackage

### sv/c8x_req_if.sv
// Request channel: operation code, address, data byte and keypad
`timescale 1ns / 1ps
interface c8x_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [15:0] keypad;

    modport source (output valid, func, address, write_data, keypad, input ready);
    modport sink   (input valid, func, address, write_data, keypad, output ready);
endinterface

### sv/c8x_rsp_if.sv
// Result channel: machine state after each request
`timescale 1ns / 1ps
interface c8x_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [11:0] program_counter;
    logic [15:0] index_value;
    logic        draw_flag;
    logic [63:0] row_pixels;
    logic [7:0]  reg_data;
    logic [7:0]  delay_value;
    logic [7:0]  sound_value;

    modport source (output valid, status, program_counter, index_value, draw_flag,
                    row_pixels, reg_data, delay_value, sound_value, input ready);
    modport sink   (input valid, status, program_counter, index_value, draw_flag,
                    row_pixels, reg_data, delay_value, sound_value, output ready);
endinterface

### sv/chip8_instruction_executor.sv
// CHIP-8 executor top level: sequencer, register file and result register
//
//   channel | dir | payload
//   i_req   | in  | func, address, write_data, keypad
//   o_rsp   | out | status, program_counter, index_value, draw_flag, row_pixels,
//           |     | reg_data, delay_value, sound_value
//
// Memory write and register read go from idle straight to the result, row read
// through S_ROW. A draw visits one or two frame rows per sprite row, and a fill
// loads registers one by one, set by the single main-memory and frame-store ports.
// After reset all 4096 memory bytes are written (font, then zeros), not ready.
// One request at a time; a held result stalls the next request.
`timescale 1ns / 1ps
`include "chip8_instruction_executor_macros.svh"
module chip8_instruction_executor import c8x_pkg::*; #(
    parameter int STACK_DEPTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    c8x_req_if.sink   i_req,
    c8x_rsp_if.source o_rsp
);
    localparam int SP_W = $clog2(STACK_DEPTH);

    t_state r_state, n_state;

    logic [MEM_AW-1:0]   r_clr_addr;
    logic [MEM_AW-1:0]   r_pc, r_pcn;
    logic [15:0]         r_i;
    logic [7:0]          r_dt, r_st;
    logic [SP_W-1:0]     r_sp;
    logic [MEM_AW-1:0]   r_stack [STACK_DEPTH];
    logic [7:0]          r_regs [16];
    logic                r_halt, r_draw;
    logic [ROW_BITS-1:0] r_row;
    logic [7:0]          r_regd;

    logic [15:0]         r_op;
    logic [7:0]          r_vx, r_vy;
    logic [15:0]         r_keys;
    logic [3:0]          r_yl, r_li;
    logic                r_hit;
    logic [ROW_BITS-1:0] r_mask_a, r_mask_b;
    logic [ROW_AW-1:0]   r_frow;

    logic                accept;
    t_func               req_func;
    t_mem_ctl            mem_ctl;
    t_frame_ctl          frm_ctl;
    logic [7:0]          mem_q;
    logic [ROW_BITS-1:0] frame_q;
    t_alu_op             alu_op;
    logic [15:0]         alu_a, alu_b, alu_res;
    logic                alu_c;

    logic [3:0]          op_grp, op_x, op_y, op_n;
    logic [7:0]          op_nn;
    logic [MEM_AW-1:0]   op_nnn;
    logic [MEM_AW-1:0]   pc2, pc4;
    logic [SP_W-1:0]     sp_inc, sp_dec;
    logic                pressed;
    logic [2*ROW_BITS-1:0] draw_wide;
    logic [ROW_AW-1:0]   row_a;

    logic                ex_bad, ex_clear, ex_draw, ex_wx, ex_wf, ex_wi;
    logic                ex_call, ex_ret, ex_setdt, ex_setst;
    logic [7:0]          ex_xd, ex_fd;
    logic [15:0]         ex_id;
    logic [MEM_AW-1:0]   ex_pcn;
    t_state              ex_next;

    assign accept   = i_req.valid && i_req.ready;
    assign req_func = t_func'(i_req.func);

    assign op_grp = r_op[15:12];
    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_nn  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign pc2    = r_pc + 12'd2;
    assign pc4    = r_pc + 12'd4;
    assign sp_inc = (r_sp == SP_W'(STACK_DEPTH - 1)) ? '0 : r_sp + SP_W'(1);
    assign sp_dec = (r_sp == '0) ? SP_W'(STACK_DEPTH - 1) : r_sp - SP_W'(1);
    assign pressed = r_keys[r_vx[3:0]];

    // Place the sprite byte at its column; the low half spills to the next row
    assign draw_wide = {mem_q, {(2*ROW_BITS-8){1'b0}}} >> r_vx[5:0];
    assign row_a = r_vy[ROW_AW-1:0] + ROW_AW'(r_yl) + ROW_AW'(r_vx[7:6]);

    c8x_alu u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_res   (alu_res),
        .o_carry (alu_c)
    );

    c8x_ram u_ram (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .o_rdata (mem_q)
    );

    c8x_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (frm_ctl),
        .o_rdata (frame_q)
    );

    // Decode the fetched instruction
    always_comb begin
        ex_bad   = 1'b0;
        ex_clear = 1'b0;
        ex_draw  = 1'b0;
        ex_wx    = 1'b0;
        ex_wf    = 1'b0;
        ex_wi    = 1'b0;
        ex_call  = 1'b0;
        ex_ret   = 1'b0;
        ex_setdt = 1'b0;
        ex_setst = 1'b0;
        ex_xd    = alu_res[7:0];
        ex_fd    = 8'd0;
        ex_id    = alu_res;
        ex_pcn   = pc2;
        ex_next  = S_DONE;
        unique case (op_grp)
            OP_SYS: begin
                if (op_n == SYS_CLS) begin
                    ex_clear = 1'b1;
                    ex_draw  = 1'b1;
                end else if (op_n == SYS_RET) begin
                    ex_ret = 1'b1;
                    ex_pcn = r_stack[sp_dec] + 12'd2;
                end else begin
                    ex_bad = 1'b1;
                end
            end
            OP_JP:   ex_pcn = op_nnn;
            OP_CALL: begin
                ex_call = 1'b1;
                ex_pcn  = op_nnn;
            end
            OP_SE:   ex_pcn = (r_vx == op_nn) ? pc4 : pc2;
            OP_SNE:  ex_pcn = (r_vx != op_nn) ? pc4 : pc2;
            OP_LD: begin
                ex_wx = 1'b1;
                ex_xd = op_nn;
            end
            OP_ADD:  ex_wx = 1'b1;
            OP_ALU: begin
                case (op_n)
                    SUB_MOV, SUB_AND, SUB_XOR: ex_wx = 1'b1;
                    SUB_ADC: begin
                        ex_wx = 1'b1;
                        ex_wf = 1'b1;
                        ex_fd = {7'd0, alu_res[8]};
                    end
                    SUB_SBC: begin
                        ex_wx = 1'b1;
                        ex_wf = 1'b1;
                        ex_fd = {7'd0, alu_c};
                    end
                    SUB_SHR: begin
                        ex_wx = 1'b1;
                        ex_wf = 1'b1;
                        ex_fd = {7'd0, r_vx[0]};
                    end
                    default: ex_bad = 1'b1;
                endcase
            end
            OP_LDI: begin
                ex_wi = 1'b1;
                ex_id = {4'd0, op_nnn};
            end
            OP_DRW: begin
                ex_draw = 1'b1;
                ex_next = S_DRAW_M;
            end
            OP_KEY: begin
                if (op_n == KEY_SKNP) begin
                    ex_pcn = pressed ? pc2 : pc4;
                end else if (op_n == KEY_SKP) begin
                    ex_pcn = pressed ? pc4 : pc2;
                end else begin
                    ex_bad = 1'b1;
                end
            end
            OP_MISC: begin
                case (op_nn)
                    MISC_ADDI: begin
                        ex_wi = 1'b1;
                        ex_wf = 1'b1;
                        ex_fd = {7'd0, alu_c | (|alu_res[15:12])};
                    end
                    MISC_GETDT: begin
                        ex_wx = 1'b1;
                        ex_xd = r_dt;
                    end
                    MISC_SETDT: ex_setdt = 1'b1;
                    MISC_SETST: ex_setst = 1'b1;
                    MISC_FILL:  ex_next  = S_LOAD_M;
                    default:    ex_bad   = 1'b1;
                endcase
            end
            default: ex_bad = 1'b1;
        endcase
        if (ex_bad) begin
            ex_next = S_OUT;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_addr == MEM_AW'(MEM_BYTES - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    unique case (req_func)
                        FN_MEM_WR: n_state = S_OUT;
                        FN_EXEC:   n_state = r_halt ? S_OUT : S_FETCH0;
                        FN_ROW_RD: n_state = S_ROW;
                        FN_REG_RD: n_state = S_OUT;
                        default:   n_state = S_OUT;
                    endcase
                end
            end
            S_FETCH0:  n_state = S_FETCH1;
            S_FETCH1:  n_state = S_FETCH2;
            S_FETCH2:  n_state = S_RDX;
            S_RDX:     n_state = S_RDY;
            S_RDY:     n_state = S_EXEC;
            S_EXEC:    n_state = ex_next;
            S_DRAW_M:  n_state = (r_yl == op_n) ? S_DONE : S_DRAW_A;
            S_DRAW_A:  n_state = S_DRAW_AW;
            S_DRAW_AW: n_state = (r_mask_b == '0) ? S_DRAW_M : S_DRAW_B;
            S_DRAW_B:  n_state = S_DRAW_BW;
            S_DRAW_BW: n_state = S_DRAW_M;
            S_LOAD_M:  n_state = S_LOAD_W;
            S_LOAD_W:  n_state = (r_li == op_x) ? S_DONE : S_LOAD_M;
            S_DONE:    n_state = S_OUT;
            S_ROW:     n_state = S_OUT;
            S_OUT:     if (o_rsp.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Drive memory ports and the shared unit from the state
    always_comb begin
        mem_ctl.we    = 1'b0;
        mem_ctl.addr  = r_pc;
        mem_ctl.wdata = 8'd0;
        frm_ctl.clear = 1'b0;
        frm_ctl.rd    = 1'b0;
        frm_ctl.raddr = r_frow;
        frm_ctl.we    = 1'b0;
        frm_ctl.waddr = r_frow;
        frm_ctl.wdata = frame_q ^ r_mask_a;
        alu_op        = ALU_ADD;
        alu_a         = {8'd0, r_vx};
        alu_b         = {8'd0, op_nn};
        unique case (r_state)
            S_CLEAR: begin
                mem_ctl.we    = 1'b1;
                mem_ctl.addr  = r_clr_addr;
                mem_ctl.wdata = (r_clr_addr < MEM_AW'(FONT_BYTES))
                              ? FONT[r_clr_addr[FONT_AW-1:0]] : 8'd0;
            end
            S_IDLE: begin
                mem_ctl.we    = accept && (req_func == FN_MEM_WR);
                mem_ctl.addr  = i_req.address;
                mem_ctl.wdata = i_req.write_data;
                frm_ctl.rd    = accept && (req_func == FN_ROW_RD);
                frm_ctl.raddr = i_req.address[ROW_AW-1:0];
            end
            S_FETCH1: mem_ctl.addr = r_pc + 12'd1;
            S_EXEC: begin
                frm_ctl.clear = ex_clear;
                if (op_grp == OP_ALU) begin
                    alu_b = {8'd0, r_vy};
                    case (op_n)
                        SUB_MOV: alu_op = ALU_PASS;
                        SUB_AND: alu_op = ALU_AND;
                        SUB_XOR: alu_op = ALU_XOR;
                        SUB_SBC: alu_op = ALU_SUB;
                        SUB_SHR: alu_op = ALU_SHR;
                        default: alu_op = ALU_ADD;
                    endcase
                end else if (op_grp == OP_MISC) begin
                    alu_a = r_i;
                    alu_b = {8'd0, r_vx};
                end
            end
            S_DRAW_M: begin
                alu_a        = r_i;
                alu_b        = {12'd0, r_yl};
                mem_ctl.addr = alu_res[MEM_AW-1:0];
            end
            S_DRAW_A: begin
                frm_ctl.rd    = 1'b1;
                frm_ctl.raddr = row_a;
            end
            S_DRAW_AW: frm_ctl.we = 1'b1;
            S_DRAW_B: begin
                frm_ctl.rd    = 1'b1;
                frm_ctl.raddr = r_frow + ROW_AW'(1);
            end
            S_DRAW_BW: begin
                frm_ctl.we    = 1'b1;
                frm_ctl.waddr = r_frow + ROW_AW'(1);
                frm_ctl.wdata = frame_q ^ r_mask_b;
            end
            S_LOAD_M: begin
                alu_a        = r_i;
                alu_b        = {12'd0, r_li};
                mem_ctl.addr = alu_res[MEM_AW-1:0];
            end
            default: ;
        endcase
    end

    // Architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pc       <= PC_RESET;
            r_i        <= '0;
            r_dt       <= '0;
            r_st       <= '0;
            r_sp       <= '0;
            r_halt     <= 1'b0;
            r_draw     <= 1'b0;
            for (int k = 0; k < STACK_DEPTH; k++) r_stack[k] <= '0;
            for (int k = 0; k < 16; k++) r_regs[k] <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_CLEAR: r_clr_addr <= r_clr_addr + MEM_AW'(1);
                S_IDLE:  if (accept) r_draw <= 1'b0;
                S_EXEC: begin
                    if (ex_bad) begin
                        r_halt <= 1'b1;
                    end else begin
                        r_draw <= ex_draw;
                        if (ex_wx) r_regs[op_x] <= ex_xd;
                        if (ex_wf) r_regs[15] <= ex_fd;
                        if (ex_wi) r_i <= ex_id;
                        if (ex_setdt) r_dt <= r_vx;
                        if (ex_setst) r_st <= r_vx;
                        if (ex_call) begin
                            r_stack[r_sp] <= r_pc;
                            r_sp          <= sp_inc;
                        end
                        if (ex_ret) r_sp <= sp_dec;
                    end
                end
                S_DRAW_M: if (r_yl == op_n) r_regs[15] <= {7'd0, r_hit};
                S_LOAD_W: r_regs[r_li] <= mem_q;
                S_DONE: begin
                    r_pc <= r_pcn;
                    if (r_dt != 8'd0) r_dt <= r_dt - 8'd1;
                end
                default: ;
            endcase
        end
    end

    // Working registers of the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_keys <= i_req.keypad;
                    r_row  <= '0;
                    r_regd <= (req_func == FN_REG_RD) ? r_regs[i_req.address[3:0]] : 8'd0;
                end
            end
            S_FETCH1: r_op[15:8] <= mem_q;
            S_FETCH2: r_op[7:0]  <= mem_q;
            S_RDX:    r_vx <= r_regs[op_x];
            S_RDY:    r_vy <= r_regs[op_y];
            S_EXEC: begin
                r_pcn <= ex_pcn;
                r_yl  <= '0;
                r_li  <= '0;
                r_hit <= 1'b0;
            end
            S_DRAW_A: begin
                r_mask_a <= draw_wide[2*ROW_BITS-1:ROW_BITS];
                r_mask_b <= draw_wide[ROW_BITS-1:0];
                r_frow   <= row_a;
            end
            S_DRAW_AW: begin
                r_hit <= r_hit | (|(frame_q & r_mask_a));
                if (r_mask_b == '0) r_yl <= r_yl + 4'd1;
            end
            S_DRAW_BW: begin
                r_hit <= r_hit | (|(frame_q & r_mask_b));
                r_yl  <= r_yl + 4'd1;
            end
            S_LOAD_W: r_li <= r_li + 4'd1;
            S_ROW:    r_row <= frame_q;
            default: ;
        endcase
    end

    // Handshake and result payload
    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = (r_state == S_OUT);
    assign o_rsp.status          = r_halt;
    assign o_rsp.program_counter = r_pc;
    assign o_rsp.index_value     = r_i;
    assign o_rsp.draw_flag       = r_draw;
    assign o_rsp.row_pixels      = r_row;
    assign o_rsp.reg_data        = r_regd;
    assign o_rsp.delay_value     = r_dt;
    assign o_rsp.sound_value     = r_st;

    // Checks
    `C8X_ASSERT_IMPLY(a_halt_sticky, i_clk, i_rst_n, r_halt, r_halt, "halt cleared")
    `C8X_ASSERT_IMPLY(a_halt_pc, i_clk, i_rst_n, r_halt, $stable(r_pc), "pc moved while halted")
    `C8X_ASSERT_NEVER(a_one_request, i_clk, i_rst_n, i_req.ready && o_rsp.valid, "overlap")
    `C8X_ASSERT_NEVER(a_sp_range, i_clk, i_rst_n, 32'(r_sp) >= STACK_DEPTH, "sp out of range")
endmodule

### sv/c8x_alu.sv
// Shared 16-bit arithmetic and logic unit
`timescale 1ns / 1ps
module c8x_alu import c8x_pkg::*; (
    input  t_alu_op     i_op,
    input  logic [15:0] i_a,
    input  logic [15:0] i_b,
    output logic [15:0] o_res,
    output logic        o_carry
);
    logic [16:0] sum;
    logic [16:0] dif;

    assign sum = {1'b0, i_a} + {1'b0, i_b};
    assign dif = {1'b0, i_a} - {1'b0, i_b};

    // Select result; carry is add carry-out or no-borrow on subtract
    always_comb begin
        o_res   = sum[15:0];
        o_carry = 1'b0;
        case (i_op)
            ALU_ADD: begin
                o_res   = sum[15:0];
                o_carry = sum[16];
            end
            ALU_SUB: begin
                o_res   = dif[15:0];
                o_carry = ~dif[16];
            end
            ALU_AND:  o_res = i_a & i_b;
            ALU_XOR:  o_res = i_a ^ i_b;
            ALU_SHR:  o_res = i_a >> 1;
            ALU_PASS: o_res = i_b;
            default:  o_res = sum[15:0];
        endcase
    end
endmodule

### sv/c8x_ram.sv
// Main memory: 4096 bytes, one port, registered read
`timescale 1ns / 1ps
module c8x_ram import c8x_pkg::*; (
    input  logic       i_clk,
    input  t_mem_ctl   i_ctl,
    output logic [7:0] o_rdata
);
    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_q;

    // Write or read one byte a cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.addr] <= i_ctl.wdata;
        end
        r_q <= r_mem[i_ctl.addr];
    end

    assign o_rdata = r_q;
endmodule

### sv/c8x_frame.sv
// Frame store: 32 rows of 64 pixels with per-row valid bits
`timescale 1ns / 1ps
module c8x_frame import c8x_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_frame_ctl          i_ctl,
    output logic [ROW_BITS-1:0] o_rdata
);
    logic [ROW_BITS-1:0]   r_mem [FRAME_ROWS];
    logic [FRAME_ROWS-1:0] r_vld;
    logic [ROW_BITS-1:0]   r_q;
    logic                  r_qv;

    // Track written rows; a clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_vld <= '0;
            end else if (i_ctl.we) begin
                r_vld[i_ctl.waddr] <= 1'b1;
            end
            if (i_ctl.rd) begin
                r_qv <= r_vld[i_ctl.raddr];
            end
        end
    end

    // Row storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        if (i_ctl.rd) begin
            r_q <= r_mem[i_ctl.raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;
endmodule
